FILE: rtl/ifp_pkg.sv
// Package for the IMU frame parser: frame geometry, header and type byte codes,
// record kind codes and the decoded frame entry type. No dependencies.
`timescale 1ns / 1ps

package ifp_pkg;

	// Bytes in one frame, from the header to the checksum (11).
	localparam int FRAME_LENGTH = 11;
	localparam int POS_W        = $clog2(FRAME_LENGTH);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Payload bytes that the decode needs: frame bytes 2 through 9.
	localparam int PAYLOAD_FIRST = 2;
	localparam int PAYLOAD_BYTES = 8;

	localparam logic [7:0] HEADER_BYTE = 8'h55;

	localparam logic [7:0] TYPE_TIME     = 8'h50;
	localparam logic [7:0] TYPE_ACCEL    = 8'h51;
	localparam logic [7:0] TYPE_GYRO     = 8'h52;
	localparam logic [7:0] TYPE_ANGLE    = 8'h53;
	localparam logic [7:0] TYPE_MAG      = 8'h54;
	localparam logic [7:0] TYPE_PRESSURE = 8'h56;

	localparam logic [2:0] KIND_TIME     = 3'd0;
	localparam logic [2:0] KIND_ACCEL    = 3'd1;
	localparam logic [2:0] KIND_GYRO     = 3'd2;
	localparam logic [2:0] KIND_ANGLE    = 3'd3;
	localparam logic [2:0] KIND_MAG      = 3'd4;
	localparam logic [2:0] KIND_PRESSURE = 3'd5;

	// One classified frame: its record kind and payload bytes 2..9 (index 0 is byte 2).
	typedef struct packed {
		logic [2:0]                      kind;
		logic [PAYLOAD_BYTES-1:0][7:0]   payload;
	} ifp_frame_t;

endpackage

FILE: rtl/ifp_front.sv
// Front end of the IMU frame parser: byte position counter, frame store and
// type classification. Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic [7:0]         rx_byte,
	output logic               frame_valid,
	output ifp_pkg::ifp_frame_t frame
);
	import ifp_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       store_q [FRAME_LENGTH];
	logic             is_header;
	logic             frame_done;
	logic             type_known;
	logic [2:0]       kind;

	assign is_header  = (rx_byte == HEADER_BYTE);
	// The completing byte lands in the checksum slot, which the decode never reads.
	assign frame_done = byte_valid && !is_header && (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (byte_valid) begin
			if (is_header) begin
				pos_q <= POS_W'(1);
			end else if (pos_q == LAST_POS) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid) begin
			if (is_header) begin
				store_q[0] <= rx_byte;
			end else begin
				store_q[pos_q] <= rx_byte;
			end
		end
	end

	always_comb begin
		type_known = 1'b1;
		kind       = KIND_TIME;
		unique case (store_q[1])
			TYPE_TIME:     kind = KIND_TIME;
			TYPE_ACCEL:    kind = KIND_ACCEL;
			TYPE_GYRO:     kind = KIND_GYRO;
			TYPE_ANGLE:    kind = KIND_ANGLE;
			TYPE_MAG:      kind = KIND_MAG;
			TYPE_PRESSURE: kind = KIND_PRESSURE;
			default:       type_known = 1'b0;
		endcase
	end

	always_comb begin
		frame.kind = kind;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			frame.payload[i] = store_q[PAYLOAD_FIRST + i];
		end
	end

	assign frame_valid = frame_done && type_known;

endmodule

FILE: rtl/ifp_queue.sv
// Short frame queue between the front end and the result formatter.
// Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ifp_pkg::ifp_frame_t wr_frame,
	output logic                full,
	input  logic                rd_en,
	output logic                rd_valid,
	output ifp_pkg::ifp_frame_t rd_frame
);
	import ifp_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

	ifp_frame_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_frame = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_frame;
		end
	end

endmodule

FILE: rtl/ifp_back.sv
// Back end of the IMU frame parser: formats a classified frame into result
// fields and holds it in the output register. Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	input  ifp_pkg::ifp_frame_t frame,
	output logic                frame_take,
	output logic                empty,
	input  logic                pop,
	output logic [2:0]          record_kind,
	output logic [15:0]         x_word,
	output logic [15:0]         y_word,
	output logic [15:0]         z_word,
	output logic [7:0]          hour,
	output logic [7:0]          minute,
	output logic [7:0]          second,
	output logic [15:0]         millis,
	output logic [31:0]         pressure,
	output logic [31:0]         height
);
	import ifp_pkg::*;

	logic        valid_q;
	logic [2:0]  kind_q;
	logic [15:0] x_q, y_q, z_q, millis_q;
	logic [7:0]  hour_q, minute_q, second_q;
	logic [31:0] pressure_q, height_q;

	logic [15:0] x_d, y_d, z_d, millis_d;
	logic [7:0]  hour_d, minute_d, second_d;
	logic [31:0] pressure_d, height_d;

	// Payload index i holds frame byte i + 2.
	always_comb begin
		x_d        = '0;
		y_d        = '0;
		z_d        = '0;
		hour_d     = '0;
		minute_d   = '0;
		second_d   = '0;
		millis_d   = '0;
		pressure_d = '0;
		height_d   = '0;
		case (frame.kind)
			KIND_TIME: begin
				hour_d   = frame.payload[3];
				minute_d = frame.payload[4];
				second_d = frame.payload[5];
				millis_d = {frame.payload[7], frame.payload[6]};
			end
			KIND_PRESSURE: begin
				pressure_d = {frame.payload[3], frame.payload[2],
					frame.payload[1], frame.payload[0]};
				height_d   = {frame.payload[7], frame.payload[6],
					frame.payload[5], frame.payload[4]};
			end
			default: begin
				x_d = {frame.payload[1], frame.payload[0]};
				y_d = {frame.payload[3], frame.payload[2]};
				z_d = {frame.payload[5], frame.payload[4]};
			end
		endcase
	end

	assign frame_take = frame_valid && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (frame_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			kind_q     <= frame.kind;
			x_q        <= x_d;
			y_q        <= y_d;
			z_q        <= z_d;
			hour_q     <= hour_d;
			minute_q   <= minute_d;
			second_q   <= second_d;
			millis_q   <= millis_d;
			pressure_q <= pressure_d;
			height_q   <= height_d;
		end
	end

	assign empty       = !valid_q;
	assign record_kind = kind_q;
	assign x_word      = x_q;
	assign y_word      = y_q;
	assign z_word      = z_q;
	assign hour        = hour_q;
	assign minute      = minute_q;
	assign second      = second_q;
	assign millis      = millis_q;
	assign pressure    = pressure_q;
	assign height      = height_q;

endmodule

FILE: rtl/imu_frame_parser_core.sv
// Top level of the IMU serial frame parser: front end, frame queue and
// result formatter. Depends on ifp_pkg, ifp_front, ifp_queue and ifp_back.
`timescale 1ns / 1ps

// The parser takes one received serial byte per transfer on the push side and
// assembles 11-byte sensor frames. A header byte 0x55 always restarts a frame,
// even in the middle of a payload; after reset, bytes fill from the start of
// the frame without waiting for a header. When the last byte of a frame
// arrives, the frame is classified by its type byte and, for a known type
// (time, acceleration, gyro, angle, magnetometer, pressure), one result is
// offered on the pop side; fields that do not belong to the record kind read
// as zero. Frames of an unknown type are dropped, and the checksum byte is not
// checked. The block takes one byte every clock cycle while full is low. A
// result takes this path: the frame is written into the two-entry frame queue
// at the transfer of the byte that completed it, is then loaded into the
// output register once that register is free or is being popped, and can be
// popped from there. full rises only when the frame queue holds two decoded
// frames that the output register cannot take, so with a reader that pops
// promptly the input never stalls.

module imu_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  record_kind,
	output logic [15:0] x_word,
	output logic [15:0] y_word,
	output logic [15:0] z_word,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic [15:0] millis,
	output logic [31:0] pressure,
	output logic [31:0] height
);
	import ifp_pkg::*;

	logic       byte_valid;
	logic       front_valid;
	ifp_frame_t front_frame;
	logic       queue_valid;
	ifp_frame_t queue_frame;
	logic       queue_take;

	// A byte transfer happens whenever push is high and the frame queue has room.
	assign byte_valid = push && !full;

	ifp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.rx_byte     (rx_byte),
		.frame_valid (front_valid),
		.frame       (front_frame)
	);

	// Decoupling queue: the front end keeps taking bytes while results wait, until the queue is full.
	ifp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_frame (front_frame),
		.full     (full),
		.rd_en    (queue_take),
		.rd_valid (queue_valid),
		.rd_frame (queue_frame)
	);

	// The formatter loads a frame when its output register is free or is being popped.
	ifp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (queue_valid),
		.frame       (queue_frame),
		.frame_take  (queue_take),
		.empty       (empty),
		.pop         (pop),
		.record_kind (record_kind),
		.x_word      (x_word),
		.y_word      (y_word),
		.z_word      (z_word),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.millis      (millis),
		.pressure    (pressure),
		.height      (height)
	);

endmodule
